### src/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator: opcodes,
// status codes, register indexes, stream widths and the structs that travel
// along the cell row and from the control to the cells.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned S_TDATA_W = 72;   // 66 bits of fields, padded to bytes
  localparam int unsigned M_TDATA_W = 136;  // 133 bits of fields, padded to bytes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [7:0]  HEADER_RST = 8'd40;
  localparam logic [31:0] LIMIT_RST  = 32'd1048576;
  localparam logic [31:0] MAXREQ_RST = 32'd100000000;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_SIZE     = 3'd1,
    ST_HEAP_FULL    = 3'd2,
    ST_TABLE_FULL   = 3'd3,
    ST_UNKNOWN      = 3'd4,
    ST_ALREADY_FREE = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER = 2'd0,
    CFG_LIMIT  = 2'd1,
    CFG_MAXREQ = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  // search token, handed from cell to cell once per cycle
  typedef struct packed {
    logic        valid;
    logic        hit;        // a live block starts at the request address
    logic        hit_free;
    logic [31:0] hit_size;
    logic        fit;        // first free live block big enough
    logic [31:0] fit_start;
    logic [31:0] fit_size;
  } scan_tok_t;

  // table update, broadcast to every cell
  typedef struct packed {
    logic        new_en;
    logic [31:0] new_start;
    logic [31:0] new_size;
    logic        set_en;     // mark the block at set_start free
    logic [31:0] set_start;
    logic        clr_en;     // mark the block at clr_start used
    logic [31:0] clr_start;
  } commit_t;

endpackage

### src/ffba_cell.sv
// ----------------------------------------------------------------------------
// ffba_cell
// One table entry: start, size and free mark of a block. Checks the passing
// search token against its entry and hands it on; applies table updates.
// ----------------------------------------------------------------------------
module ffba_cell import ffba_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 9
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  scan_tok_t      tok_i,
  output scan_tok_t      tok_o,
  input  logic [31:0]    req_size_i,
  input  logic [31:0]    req_addr_i,
  input  logic [CW-1:0]  count_i,
  input  commit_t        cmt_i
);

  logic [31:0] start_q;
  logic [31:0] size_q;
  logic        free_q;
  scan_tok_t   tok_q, tok_d;
  logic        live;

  assign live = (count_i > CW'(IDX));

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && live) begin
      if (!tok_i.hit && start_q == req_addr_i) begin
        tok_d.hit      = 1'b1;
        tok_d.hit_free = free_q;
        tok_d.hit_size = size_q;
      end
      if (!tok_i.fit && free_q && size_q >= req_size_i) begin
        tok_d.fit       = 1'b1;
        tok_d.fit_start = start_q;
        tok_d.fit_size  = size_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // entry contents hold no reset value
  always_ff @(posedge clk_i) begin
    if (cmt_i.new_en && count_i == CW'(IDX)) begin
      start_q <= cmt_i.new_start;
      size_q  <= cmt_i.new_size;
      free_q  <= 1'b0;
    end else if (live) begin
      if (cmt_i.set_en && start_q == cmt_i.set_start) begin
        free_q <= 1'b1;
      end else if (cmt_i.clr_en && start_q == cmt_i.clr_start) begin
        free_q <= 1'b0;
      end
    end
  end

  assign tok_o = tok_q;

endmodule

### src/ffba_chain.sv
// ----------------------------------------------------------------------------
// ffba_chain
// Row of table cells in creation order. The search token enters at cell 0
// and passes through the register of every cell before it leaves the last cell.
// ----------------------------------------------------------------------------
module ffba_chain import ffba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = 256,
  parameter int unsigned CW         = 9
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  scan_tok_t      tok_i,
  output scan_tok_t      tok_o,
  input  logic [31:0]    req_size_i,
  input  logic [31:0]    req_addr_i,
  input  logic [CW-1:0]  count_i,
  input  commit_t        cmt_i
);

  scan_tok_t link [MAX_BLOCKS+1];

  assign link[0] = tok_i;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    ffba_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tok_i      (link[g]),
      .tok_o      (link[g+1]),
      .req_size_i (req_size_i),
      .req_addr_i (req_addr_i),
      .count_i    (count_i),
      .cmt_i      (cmt_i)
    );
  end

  assign tok_o = link[MAX_BLOCKS];

endmodule

### src/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap block allocator without splitting. Block table lives in a
// row of cells; one search token walks the row per request.
// ----------------------------------------------------------------------------
// Requests: one at a time; the token walks the cell row one cell per cycle,
//   and the next request waits for its table update.
// Reset: registers go to 40 / 1048576 / 100000000, counters and break clear;
//   table entries stay undefined, entries at or above the block count are
//   never consulted, so no clearing pass is needed.
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // opcode[1:0], request_size[33:2], block_address[65:34], zero pad
  input  logic [S_TDATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // result_address[31:0], status[34:32], free_block_count[43:35],
  // free_byte_count[75:44], total_block_count[84:76],
  // created_byte_count[116:85], header_byte_count[132:117], zero pad
  output logic [M_TDATA_W-1:0]  m_tdata
);

  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

  // configuration
  logic [7:0]  hdr_q;
  logic [31:0] limit_q;
  logic [31:0] maxreq_q;
  logic [7:0]  hdr_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q    <= HEADER_RST;
      limit_q  <= LIMIT_RST;
      maxreq_q <= MAXREQ_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEADER: hdr_q    <= cfg_wdata_i[7:0];
        CFG_LIMIT:  limit_q  <= cfg_wdata_i;
        CFG_MAXREQ: maxreq_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign hdr_eff = (hdr_q == 8'd0) ? 8'd1 : hdr_q;

  // control and allocator state
  state_e        state_q, state_d;
  logic          start_q;
  op_e           op_q;
  logic [31:0]   size_q;
  logic [31:0]   addr_q;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   brk_q, brk_d;
  logic [CW-1:0] fblk_q, fblk_d;
  logic [31:0]   fbyte_q, fbyte_d;
  logic [31:0]   created_q, created_d;
  logic [32:0]   base_q;
  logic [15:0]   hdr_tot_q;
  scan_tok_t     scan_q;
  scan_tok_t     head_tok, tail_tok;
  commit_t       cmt;

  logic                 accept;
  logic                 commit_en;
  logic                 m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;

  assign accept    = s_tvalid && s_tready;
  assign commit_en = (state_q == S_FINISH) && (!m_valid_q || m_tready);

  always_comb begin
    head_tok       = '0;
    head_tok.valid = start_q;
  end

  ffba_chain #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .CW         (CW)
  ) u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tok_i      (head_tok),
    .tok_o      (tail_tok),
    .req_size_i (size_q),
    .req_addr_i (addr_q),
    .count_i    (count_q),
    .cmt_i      (cmt)
  );

  // allocate decision
  logic        bad;
  logic        table_full;
  logic [33:0] end_off;
  logic        heap_full;
  status_e     a_st;
  logic [31:0] a_res;
  logic        a_reuse, a_new;

  assign bad        = (size_q == 32'd0) || (size_q > maxreq_q);
  assign table_full = (count_q == CW'(MAX_BLOCKS));
  assign end_off    = {1'b0, base_q} + {2'b00, size_q};
  assign heap_full  = end_off > {2'b00, limit_q};

  always_comb begin
    a_st    = ST_OK;
    a_res   = '0;
    a_reuse = 1'b0;
    a_new   = 1'b0;
    if (bad) begin
      a_st = ST_BAD_SIZE;
    end else if (scan_q.fit) begin
      a_reuse = 1'b1;
      a_res   = scan_q.fit_start;
    end else if (table_full) begin
      a_st = ST_TABLE_FULL;
    end else if (heap_full) begin
      a_st = ST_HEAP_FULL;
    end else begin
      a_new = 1'b1;
      a_res = base_q[31:0];
    end
  end

  // per-opcode decision
  status_e     st;
  logic [31:0] res;
  logic        use_alloc, mark;
  logic        take_reuse, take_new;

  always_comb begin
    st        = ST_OK;
    res       = '0;
    use_alloc = 1'b0;
    mark      = 1'b0;
    unique case (op_q)
      OP_ALLOC: use_alloc = 1'b1;
      OP_FREE: begin
        if (addr_q != 32'd0) begin
          if (!scan_q.hit)         st   = ST_UNKNOWN;
          else if (scan_q.hit_free) st  = ST_ALREADY_FREE;
          else                      mark = 1'b1;
        end
      end
      OP_REALLOC: begin
        if (addr_q == 32'd0) begin
          use_alloc = 1'b1;
        end else if (bad) begin
          st = ST_BAD_SIZE;
        end else if (!scan_q.hit) begin
          st = ST_UNKNOWN;
        end else if (scan_q.hit_free) begin
          st = ST_ALREADY_FREE;
        end else if (scan_q.hit_size >= size_q) begin
          res = addr_q;
        end else begin
          use_alloc = 1'b1;
          mark      = (a_st == ST_OK);
        end
      end
      default: ;
    endcase
    if (use_alloc) begin
      st  = a_st;
      res = a_res;
    end
  end

  assign take_reuse = use_alloc && a_reuse;
  assign take_new   = use_alloc && a_new;

  always_comb begin
    fblk_d    = fblk_q + CW'(mark) - CW'(take_reuse);
    fbyte_d   = fbyte_q + (mark ? scan_q.hit_size : 32'd0)
                - (take_reuse ? scan_q.fit_size : 32'd0);
    count_d   = count_q + CW'(take_new);
    created_d = created_q + (take_new ? size_q : 32'd0);
    brk_d     = take_new ? end_off[31:0] : brk_q;
  end

  always_comb begin
    cmt.new_en    = commit_en && take_new;
    cmt.new_start = base_q[31:0];
    cmt.new_size  = size_q;
    cmt.set_en    = commit_en && mark;
    cmt.set_start = addr_q;
    cmt.clr_en    = commit_en && take_reuse;
    cmt.clr_start = scan_q.fit_start;
  end

  // state machine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    s_tready = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (tail_tok.valid) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (commit_en) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= 1'b0;
      count_q   <= '0;
      brk_q     <= '0;
      fblk_q    <= '0;
      fbyte_q   <= '0;
      created_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      start_q <= accept;
      if (commit_en) begin
        count_q   <= count_d;
        brk_q     <= brk_d;
        fblk_q    <= fblk_d;
        fbyte_q   <= fbyte_d;
        created_q <= created_d;
        m_valid_q <= 1'b1;
      end else if (m_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // request, scan result and precomputed sums; no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(s_tdata[1:0]);
      size_q <= s_tdata[33:2];
      addr_q <= s_tdata[65:34];
    end
    if (state_q == S_SCAN) begin
      base_q    <= {1'b0, brk_q} + 33'(hdr_eff);
      hdr_tot_q <= 16'(32'(count_q) * 32'(hdr_eff));
      if (tail_tok.valid) scan_q <= tail_tok;
    end
    if (commit_en) begin
      m_data_q <= {3'b000,
                   hdr_tot_q + (take_new ? 16'(hdr_eff) : 16'd0),
                   created_d,
                   9'(count_d),
                   fbyte_d,
                   9'(fblk_d),
                   st,
                   res};
    end
  end

  assign m_tvalid = m_valid_q;
  assign m_tdata  = m_data_q;

  // checks
  a_free_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fblk_q <= count_q)
    else $error("free block count exceeds block count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_BLOCKS))
    else $error("block count beyond table depth");

  a_tail_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_tok.valid |-> state_q == S_SCAN)
    else $error("search token left the row outside a scan");

  a_break_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_en && take_new) |=> brk_q > $past(brk_q))
    else $error("break did not advance on a new block");

endmodule
